/* sv/medf_pkg.sv */
// Shared types and constants for the MIDI event delay queue.
// Used by the controller, the datapath, the top level and the checker.
package medf_pkg;

  localparam int DEFAULT_QUEUE_DEPTH  = 1024;
  localparam int DEFAULT_MAX_PER_TICK = 64;

  localparam int DELAY_W = 20;
  localparam int SIZE_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;

  localparam logic [SIZE_W-1:0] EVENT_BYTES = SIZE_W'(3);

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEXT
  } state_t;

  typedef struct packed {
    logic enq;
    logic start_read;
    logic pop;
    logic load_out;
    logic last;
    logic advance_now;
  } cmd_t;

  typedef struct packed {
    logic head_due;
    logic out_free;
  } status_t;

endpackage

/* sv/medf_ctrl.sv */
// Controller state machine for the MIDI event delay queue.
// Depends on medf_pkg; drives commands into medf_datapath.
module medf_ctrl #(
  parameter int MAX_PER_TICK = medf_pkg::DEFAULT_MAX_PER_TICK
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              operation,
  output logic              in_stall,
  input  medf_pkg::status_t status,
  output medf_pkg::cmd_t    cmd
);
  import medf_pkg::*;

  localparam int CNT_W = $clog2(MAX_PER_TICK + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    more       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op_t'(operation) == OP_TICK) begin
            cmd.start_read = 1'b1;
            count_next     = '0;
            state_next     = ST_CHECK;
          end else begin
            cmd.enq = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status.head_due) begin
          cmd.pop    = 1'b1;
          count_next = count + 1'b1;
          state_next = ST_NEXT;
        end else begin
          cmd.advance_now = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_NEXT: begin
        // Held item is last unless head is due and count < MAX_PER_TICK.
        more = status.head_due && (count < CNT_W'(MAX_PER_TICK));
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = !more;
          if (more) begin
            cmd.pop    = 1'b1;
            count_next = count + 1'b1;
          end else begin
            cmd.advance_now = 1'b1;
            state_next      = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* sv/medf_datapath.sv */
// Datapath of the MIDI event delay queue: event memory, pointers, time counter
// and output register. Depends on medf_pkg; commanded by medf_ctrl.
module medf_datapath #(
  parameter int QUEUE_DEPTH = medf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  medf_pkg::cmd_t                cmd,
  output medf_pkg::status_t             status,
  input  logic                          cfg_valid,
  input  logic [medf_pkg::DELAY_W-1:0]  cfg_data,
  input  logic [medf_pkg::SIZE_W-1:0]   event_size,
  input  logic [medf_pkg::BYTE_W-1:0]   status_byte,
  input  logic [medf_pkg::BYTE_W-1:0]   data_first,
  input  logic [medf_pkg::BYTE_W-1:0]   data_second,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [medf_pkg::BYTE_W-1:0]   out_status,
  output logic [medf_pkg::BYTE_W-1:0]   out_data_first,
  output logic [medf_pkg::BYTE_W-1:0]   out_data_second,
  output logic [medf_pkg::TIME_W-1:0]   release_time,
  output logic                          last_of_tick
);
  import medf_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W  = 3 * BYTE_W;
  localparam int ENTRY_W = TIME_W + DATA_W;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [DATA_W-1:0]  cand;

  logic [DELAY_W-1:0] delay;
  logic [TIME_W-1:0]  now;
  logic [IDX_W-1:0]   head, tail, head_inc, tail_inc, rd_addr;
  logic [FILL_W-1:0]  fill;
  logic               do_enq;

  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign rd_addr  = cmd.pop ? head_inc : head;
  assign do_enq   = cmd.enq && (event_size == EVENT_BYTES)
                    && (fill != FILL_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[tail] <= {now + TIME_W'(delay), status_byte, data_first, data_second};
    end
    if (cmd.start_read || cmd.pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= '0;
      now   <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else begin
      if (cfg_valid) begin
        delay <= cfg_data;
      end
      if (cmd.advance_now) begin
        now <= now + 1'b1;
      end
      if (do_enq) begin
        tail <= tail_inc;
        fill <= fill + 1'b1;
      end else if (cmd.pop) begin
        head <= head_inc;
        fill <= fill - 1'b1;
      end
    end
  end

  // The popped head waits here until the entry behind it shows whether it ends the tick.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      cand <= rd_data[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= cand[DATA_W-1 -: BYTE_W];
      out_data_first  <= cand[2*BYTE_W-1 -: BYTE_W];
      out_data_second <= cand[BYTE_W-1:0];
      release_time    <= now;
      last_of_tick    <= cmd.last;
    end
  end

  assign status.head_due = (fill != '0) && (rd_data[ENTRY_W-1 -: TIME_W] == now);
  assign status.out_free = !out_valid || !out_stall;

endmodule

/* sv/midi_event_delay_fifo_unit.sv */
// Top level of the MIDI event delay queue: controller plus datapath.
// Depends on medf_pkg, medf_ctrl and medf_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    operation, event_size, status_byte,
//                                              data_first, data_second
//   out      output     out_valid / out_stall  out_status, out_data_first,
//                                              out_data_second, release_time, last_of_tick
//   cfg      input      cfg_valid / cfg_ready  cfg_data (delay in sample ticks)
//
// An event item is taken without stalling the input. A tick item stalls the input until its
// due events (at most MAX_PER_TICK) have gone out one at a time, through the one read port of the event memory: each
// release reads the next head to decide whether it ends the tick.
// Output stalls hold back a tick's releases; the input stays stalled meanwhile.
// Reset is synchronous; the event memory needs no clearing pass, the fill count guards it.
module midi_event_delay_fifo_unit #(
  parameter int QUEUE_DEPTH  = medf_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int MAX_PER_TICK = medf_pkg::DEFAULT_MAX_PER_TICK
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [medf_pkg::SIZE_W-1:0]   event_size,
  input  logic [medf_pkg::BYTE_W-1:0]   status_byte,
  input  logic [medf_pkg::BYTE_W-1:0]   data_first,
  input  logic [medf_pkg::BYTE_W-1:0]   data_second,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [medf_pkg::BYTE_W-1:0]   out_status,
  output logic [medf_pkg::BYTE_W-1:0]   out_data_first,
  output logic [medf_pkg::BYTE_W-1:0]   out_data_second,
  output logic [medf_pkg::TIME_W-1:0]   release_time,
  output logic                          last_of_tick,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [medf_pkg::DELAY_W-1:0]  cfg_data
);
  import medf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  medf_ctrl #(
    .MAX_PER_TICK (MAX_PER_TICK)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  medf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .event_size      (event_size),
    .status_byte     (status_byte),
    .data_first      (data_first),
    .data_second     (data_second),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_first  (out_data_first),
    .out_data_second (out_data_second),
    .release_time    (release_time),
    .last_of_tick    (last_of_tick)
  );

endmodule

/* sv/medf_checker.sv */
// Port-level checks for the MIDI event delay queue, bound to the top level.
// Depends on medf_pkg and midi_event_delay_fifo_unit.
module medf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [medf_pkg::BYTE_W-1:0]   out_status,
  input logic [medf_pkg::TIME_W-1:0]   release_time,
  input logic                          last_of_tick
);
  import medf_pkg::*;

  // A held item keeps its status byte, release time and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(release_time)
                               && $stable(last_of_tick))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A tick stalls the input right after it is taken, to look at the queue head.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op_t'(operation) == OP_TICK) |=> in_stall)
    else $error("input taken right after a tick");

  // Until the last release of a tick goes out, no new item may enter.
  a_tick_unfinished: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_tick |-> in_stall)
    else $error("input taken before the tick finished releasing");

endmodule

bind midi_event_delay_fifo_unit medf_checker u_medf_checker (.*);
